@@ rtl/totp_pkg.sv @@
// Package for the TOTP code generator: shared types, constants and codes.
// No dependencies.
package totp_pkg;

  localparam int KEY_WORDS = 5;
  localparam logic [5:0] KEY_MAX = 6'd40;
  localparam logic [31:0] CODE_MOD = 32'd1000000;

  typedef enum logic [2:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_KEY4 = 3'd4,
    REG_KLEN = 3'd5
  } reg_idx_t;

  // Which 64-byte block the compression unit works on.
  typedef enum logic [1:0] {
    BLK_IPAD  = 2'd0,
    BLK_MSG   = 2'd1,
    BLK_OPAD  = 2'd2,
    BLK_INNER = 2'd3
  } blk_sel_t;

  typedef struct packed {
    logic     load_step;
    logic     div_step;
    logic     init_hash;
    blk_sel_t blk;
    logic     load_block;
    logic     round;
    logic     add_hash;
    logic     save_inner;
    logic     trunc;
    logic     mod_step;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic round_last;
    logic mod_done;
  } dp_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

endpackage

@@ rtl/totp_if.sv @@
// Valid/ready channel interfaces for the TOTP code generator.
// Depends on nothing.
interface totp_in_if;
  logic        valid;
  logic        ready;
  logic [62:0] unix_seconds;
  modport source (output valid, output unix_seconds, input ready);
  modport sink (input valid, input unix_seconds, output ready);
endinterface

interface totp_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] otp_code;
  logic [4:0]  seconds_left;
  modport source (output valid, output otp_code, output seconds_left, input ready);
  modport sink (input valid, input otp_code, input seconds_left, output ready);
endinterface

interface totp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/totp_datapath.sv @@
// Datapath: step division by reciprocal multiplication, SHA-1 round unit with
// message schedule, truncation and modulo. Depends on totp_pkg.
module totp_datapath import totp_pkg::*; #(
  parameter int STEP_SECONDS = 30
) (
  input  logic        clk,
  input  logic [62:0] unix_seconds,
  input  logic [319:0] key,
  input  logic [5:0]  key_len,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  output logic [19:0] otp_code,
  output logic [4:0]  seconds_left
);

  localparam int SW = $clog2(STEP_SECONDS + 1);
  localparam int DL = $clog2(STEP_SECONDS);
  localparam logic [127:0] STEP_RECIP =
    ((128'd1 << (63 + DL)) / 128'(STEP_SECONDS)) + 128'd1;
  localparam logic [31:0] MOD_RECIP = 32'(((64'd1 << 51) / 64'(CODE_MOD)) + 64'd1);

  // The quotient is accumulated from four 32 x 32 partial products.
  logic [62:0] secs_r, secs_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [1:0] dcnt_r, dcnt_nxt;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [127:0] mul_add;
  logic [62:0] quo;
  logic [SW-1:0] rem;

  logic [511:0] kpad;
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0] h_r [5];
  logic [31:0] h_nxt [5];
  logic [159:0] inner_r, inner_nxt;
  logic [6:0] rcnt_r, rcnt_nxt;
  logic [31:0] f, k, t, wnew;
  logic [511:0] blk;
  logic [159:0] mac;
  logic [159:0] hsum;
  logic [3:0] off;
  logic [31:0] code_r, code_nxt;
  logic [63:0] mprod_r, mprod_nxt;
  logic mcnt_r, mcnt_nxt;
  logic [19:0] mq, mrem;
  logic [5:0] klen;

  assign klen = (key_len > KEY_MAX) ? KEY_MAX : key_len;

  always_comb begin
    mul_a = dcnt_r[1] ? {1'b0, secs_r[62:32]} : secs_r[31:0];
    mul_b = dcnt_r[0] ? STEP_RECIP[63:32] : STEP_RECIP[31:0];
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    case (dcnt_r)
      2'd0:       mul_add = {64'd0, mul_p};
      2'd1, 2'd2: mul_add = {32'd0, mul_p, 32'd0};
      default:    mul_add = {mul_p, 64'd0};
    endcase
  end

  assign quo = 63'(acc_r >> (63 + DL));
  assign rem = secs_r[SW-1:0] - quo[SW-1:0] * SW'(STEP_SECONDS);

  always_comb begin
    kpad = '0;
    for (int i = 0; i < int'(KEY_MAX); i++) begin
      kpad[511 - 8*i -: 8] = (6'(i) < klen) ? key[319 - 8*i -: 8] : 8'h00;
    end
  end

  always_comb begin
    case (cmd.blk)
      BLK_IPAD:  blk = kpad ^ {64{8'h36}};
      BLK_OPAD:  blk = kpad ^ {64{8'h5C}};
      BLK_MSG:   blk = {1'b0, quo, 8'h80, 376'd0, 64'd576};
      BLK_INNER: blk = {inner_r, 8'h80, 280'd0, 64'd672};
      default:   blk = '0;
    endcase
  end

  always_comb begin
    if (rcnt_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); k = 32'h5A827999;
    end else if (rcnt_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = 32'h6ED9EBA1;
    end else if (rcnt_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = 32'h8F1BBCDC;
    end else begin
      f = b_r ^ c_r ^ d_r; k = 32'hCA62C1D6;
    end
    t = rotl(a_r, 5) + f + e_r + k + w_r[0];
    wnew = rotl(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0], 1);
  end

  assign mac = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};
  assign hsum = {h_r[0] + a_r, h_r[1] + b_r, h_r[2] + c_r, h_r[3] + d_r, h_r[4] + e_r};
  assign off = mac[3:0];
  assign mq = 20'(mprod_r >> 51);
  assign mrem = code_r[19:0] - mq * CODE_MOD[19:0];

  always_comb begin
    secs_nxt = secs_r; acc_nxt = acc_r; dcnt_nxt = dcnt_r;
    w_nxt = w_r; a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; e_nxt = e_r;
    h_nxt = h_r; inner_nxt = inner_r; rcnt_nxt = rcnt_r;
    code_nxt = code_r; mprod_nxt = mprod_r; mcnt_nxt = mcnt_r;
    if (cmd.load_step) begin
      secs_nxt = unix_seconds; acc_nxt = '0; dcnt_nxt = '0;
    end
    if (cmd.div_step) begin
      acc_nxt = acc_r + mul_add;
      dcnt_nxt = dcnt_r + 2'd1;
    end
    if (cmd.init_hash) begin
      h_nxt[0] = 32'h67452301; h_nxt[1] = 32'hEFCDAB89; h_nxt[2] = 32'h98BADCFE;
      h_nxt[3] = 32'h10325476; h_nxt[4] = 32'hC3D2E1F0;
    end
    if (cmd.load_block) begin
      for (int i = 0; i < 16; i++) w_nxt[i] = blk[511 - 32*i -: 32];
      a_nxt = h_r[0]; b_nxt = h_r[1]; c_nxt = h_r[2]; d_nxt = h_r[3]; e_nxt = h_r[4];
      rcnt_nxt = '0;
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
      w_nxt[15] = wnew;
      e_nxt = d_r; d_nxt = c_r; c_nxt = rotl(b_r, 30); b_nxt = a_r; a_nxt = t;
      rcnt_nxt = rcnt_r + 7'd1;
    end
    if (cmd.add_hash) begin
      h_nxt[0] = hsum[159:128]; h_nxt[1] = hsum[127:96]; h_nxt[2] = hsum[95:64];
      h_nxt[3] = hsum[63:32]; h_nxt[4] = hsum[31:0];
    end
    if (cmd.save_inner) inner_nxt = hsum;
    if (cmd.trunc) begin
      code_nxt = mac[159 - 8*off -: 32] & 32'h7FFFFFFF;
      mcnt_nxt = 1'b0;
    end
    if (cmd.mod_step) begin
      if (!mcnt_r) mprod_nxt = {32'd0, code_r} * {32'd0, MOD_RECIP};
      else code_nxt = {12'd0, mrem};
      mcnt_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    secs_r <= secs_nxt; acc_r <= acc_nxt; dcnt_r <= dcnt_nxt;
    w_r <= w_nxt; a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt; e_r <= e_nxt;
    h_r <= h_nxt; inner_r <= inner_nxt; rcnt_r <= rcnt_nxt;
    code_r <= code_nxt; mprod_r <= mprod_nxt; mcnt_r <= mcnt_nxt;
  end

  assign sts.div_done = (dcnt_r == 2'd3);
  assign sts.round_last = (rcnt_r == 7'd79);
  assign sts.mod_done = mcnt_r;
  assign otp_code = (klen == '0) ? 20'd0 : code_r[19:0];
  assign seconds_left = 5'((SW+1)'(STEP_SECONDS) - {1'b0, rem});

endmodule

@@ rtl/totp_ctrl.sv @@
// Controller state machine sequencing division, four SHA-1 blocks and reduction.
// Depends on totp_pkg.
module totp_ctrl import totp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_fire,
  input  logic    out_free,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy,
  output logic    done
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DIV   = 8'b00000010,
    S_LOAD  = 8'b00000100,
    S_ROUND = 8'b00001000,
    S_ADD   = 8'b00010000,
    S_TRUNC = 8'b00100000,
    S_MOD   = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  blk_sel_t blk_r, blk_nxt;

  always_comb begin
    state_nxt = state_r; blk_nxt = blk_r; cmd = '0; cmd.blk = blk_r;
    case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.load_step = 1'b1; state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.init_hash = 1'b1; blk_nxt = BLK_IPAD; state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_block = 1'b1; state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (sts.round_last) state_nxt = S_ADD;
      end
      S_ADD: begin
        state_nxt = S_LOAD;
        case (blk_r)
          BLK_IPAD: begin
            cmd.add_hash = 1'b1; blk_nxt = BLK_MSG;
          end
          // The inner digest is saved and the outer hash restarts from the
          // initial values.
          BLK_MSG: begin
            cmd.save_inner = 1'b1; cmd.init_hash = 1'b1; blk_nxt = BLK_OPAD;
          end
          BLK_OPAD: begin
            cmd.add_hash = 1'b1; blk_nxt = BLK_INNER;
          end
          default: begin
            cmd.add_hash = 1'b1; state_nxt = S_TRUNC;
          end
        endcase
      end
      S_TRUNC: begin
        cmd.trunc = 1'b1; state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) state_nxt = S_DONE;
      end
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; blk_r <= BLK_IPAD;
    end else begin
      state_r <= state_nxt; blk_r <= blk_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE) && out_free;

endmodule

@@ rtl/totp_code_generator_core.sv @@
// Each accepted item is processed in order: step division, four SHA-1 blocks,
// truncation, modulo reduction, then a load into the output register.
// One item is processed at a time; the SHA-1 round unit does one round per cycle.
// A result waits in the output register; input stalls until the prior result is loaded there.
// Synchronous active-low reset returns the controller to idle and clears the key.
// Top level of the TOTP code generator. Depends on totp_pkg, totp_if,
// totp_ctrl and totp_datapath.
module totp_code_generator_core import totp_pkg::*; #(
  parameter int STEP_SECONDS = 30
) (
  input logic clk,
  input logic rst_n,
  totp_in_if.sink    in_ch,
  totp_out_if.source out_ch,
  totp_cfg_if.sink   cfg_ch
);

  logic [63:0] key_r [KEY_WORDS];
  logic [5:0] klen_r;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic busy, done, in_fire, out_fire, out_free;
  logic [19:0] dp_code;
  logic [4:0] dp_left;
  logic out_valid_r;
  logic [19:0] out_code_r;
  logic [4:0] out_left_r;

  assign in_ch.ready = !busy;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.otp_code = out_code_r;
  assign out_ch.seconds_left = out_left_r;
  assign out_fire = out_valid_r && out_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_WORDS; i++) key_r[i] <= '0;
      klen_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_KEY0: key_r[0] <= cfg_ch.data;
        REG_KEY1: key_r[1] <= cfg_ch.data;
        REG_KEY2: key_r[2] <= cfg_ch.data;
        REG_KEY3: key_r[3] <= cfg_ch.data;
        REG_KEY4: key_r[4] <= cfg_ch.data;
        REG_KLEN: klen_r <= cfg_ch.data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_code_r <= dp_code;
      out_left_r <= dp_left;
    end
  end

  totp_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_free, .sts, .cmd, .busy, .done
  );

  totp_datapath #(.STEP_SECONDS(STEP_SECONDS)) u_dp (
    .clk,
    .unix_seconds(in_ch.unix_seconds),
    .key({key_r[0], key_r[1], key_r[2], key_r[3], key_r[4]}),
    .key_len(klen_r),
    .cmd, .sts,
    .otp_code(dp_code),
    .seconds_left(dp_left)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready) else $error("item accepted while busy");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> ($stable(out_ch.otp_code) &&
    $stable(out_ch.seconds_left))) else $error("result changed while waiting");
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.otp_code < 20'd1000000) else $error("code out of range");
`endif

endmodule
